/* src/sha1bs_pkg.sv */
// Shared types and constants for the SHA-1 byte stream hasher.
// No dependencies; used by scoped name in wmem, round, top and digest checker.
package sha1bs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned WORDS    = 16;
    localparam int unsigned ADDR_W   = $clog2(WORDS);
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned ROUND_W  = 7;

    localparam logic [7:0]        PAD_MARK   = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'(ROUNDS - 1);

    // five chaining words, index 0 = H0 / a
    typedef logic [4:0][WORD_W-1:0] t_chain;

    localparam t_chain H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                 32'hefcdab89, 32'h67452301};

    typedef enum logic [1:0] {
        PH_CH   = 2'd0,
        PH_PAR1 = 2'd1,
        PH_MAJ  = 2'd2,
        PH_PAR2 = 2'd3
    } t_phase;

    localparam logic [3:0][WORD_W-1:0] K_ROUND = {32'hca62c1d6, 32'h8f1bbcdc,
                                                  32'h6ed9eba1, 32'h5a827999};

    typedef struct packed {
        t_phase phase;
        logic   expand;   // round 16 and up: schedule word is recomputed
    } t_round_ctl;

endpackage

/* src/sha1bs_wmem.sv */
// Message schedule store: 16 x 32 synchronous RAM, one write, two reads.
// Read data is registered. Uses sha1bs_pkg.
module sha1bs_wmem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [sha1bs_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [sha1bs_pkg::WORD_W-1:0]  i_wdata,
    input  logic [sha1bs_pkg::ADDR_W-1:0]  i_raddr0,
    input  logic [sha1bs_pkg::ADDR_W-1:0]  i_raddr1,
    output logic [sha1bs_pkg::WORD_W-1:0]  o_rdata0,
    output logic [sha1bs_pkg::WORD_W-1:0]  o_rdata1
);

    logic [sha1bs_pkg::WORD_W-1:0] mem [sha1bs_pkg::WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

/* src/sha1bs_round.sv */
// One SHA-1 round: schedule expansion and the a..e update.
// Purely combinational; uses sha1bs_pkg.
module sha1bs_round (
    input  sha1bs_pkg::t_round_ctl          i_ctl,
    input  sha1bs_pkg::t_chain              i_abcde,
    input  logic [sha1bs_pkg::WORD_W-1:0]   i_w_m3,
    input  logic [sha1bs_pkg::WORD_W-1:0]   i_w_m8,
    input  logic [sha1bs_pkg::WORD_W-1:0]   i_w_m14,
    input  logic [sha1bs_pkg::WORD_W-1:0]   i_w_m16,
    output sha1bs_pkg::t_chain              o_abcde,
    output logic [sha1bs_pkg::WORD_W-1:0]   o_w
);

    logic [31:0] w_x, w_cur, f, t;
    logic [31:0] a, b, c, d, e;

    always_comb begin
        a = i_abcde[0];
        b = i_abcde[1];
        c = i_abcde[2];
        d = i_abcde[3];
        e = i_abcde[4];
        w_x   = i_w_m3 ^ i_w_m8 ^ i_w_m14 ^ i_w_m16;
        o_w   = {w_x[30:0], w_x[31]};
        w_cur = i_ctl.expand ? o_w : i_w_m16;
        unique case (i_ctl.phase)
            sha1bs_pkg::PH_CH:   f = d ^ (b & (c ^ d));
            sha1bs_pkg::PH_MAJ:  f = (b & c) | (d & (b | c));
            sha1bs_pkg::PH_PAR1,
            sha1bs_pkg::PH_PAR2: f = b ^ c ^ d;
            default:             f = b ^ c ^ d;
        endcase
        t = {a[26:0], a[31:27]} + f + e + sha1bs_pkg::K_ROUND[i_ctl.phase] + w_cur;
        o_abcde = {d, c, {b[1:0], b[31:2]}, a, t};
    end

endmodule

/* src/sha1_byte_stream_hasher_top.sv */
// SHA-1 byte stream hasher, top level: control sequencer, byte packing,
// padding and digest output. Uses sha1bs_pkg, sha1bs_wmem, sha1bs_round.
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one transfer per item, carrying
//   an optional message byte (i_data_byte, qualified by i_byte_valid) and
//   i_end_of_message. Output channel (o_out_valid / i_out_ready): five
//   transfers per finished message, digest words H0..H4 with o_word_index,
//   o_last_word set on word 4.
// Flow control
//   Bytes are taken one per cycle while o_in_ready is high. The transfer that
//   completes a 64-byte block holds o_in_ready low while the block is
//   compressed: S_CPRE starts the reads, then 80 rounds run (one per cycle,
//   limited by the round unit and the schedule RAMs) and S_FIN folds the
//   result into the chaining words.
//   An end-of-message transfer then pads one byte per cycle, runs one or
//   two more compressions and emits five words, one per cycle while the
//   receiver takes them.
// Reset and stalls
//   Reset loads the SHA-1 initial values and clears counts and valid flags.
//   The digest words leave through an output register; a receiver stall
//   holds the current word and freezes the sequence, nothing is dropped.
//   o_in_ready stays low until the last digest word is in that register.
module sha1_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam int unsigned AW = sha1bs_pkg::ADDR_W;
    localparam int unsigned FW = sha1bs_pkg::FILL_W;
    localparam int unsigned RW = sha1bs_pkg::ROUND_W;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,  // taking message bytes
        S_PAD  = 6'b000010,  // generating pad / length bytes
        S_CPRE = 6'b000100,  // load a..e, issue reads for round 0
        S_RND  = 6'b001000,  // 80 rounds
        S_FIN  = 6'b010000,  // add into chaining words
        S_OUT  = 6'b100000   // emit digest words
    } t_state;

    t_state               r_state, n_state;
    logic [FW-1:0]        r_fill, n_fill;
    logic [31:0]          r_len, n_len;
    logic [23:0]          r_word, n_word;     // partial big-endian word
    logic [RW-1:0]        r_round, n_round;
    sha1bs_pkg::t_chain   r_abcde, n_abcde;
    sha1bs_pkg::t_chain   r_h, n_h;
    logic                 r_mark, n_mark;     // 0x80 already placed
    logic                 r_lenph, n_lenph;   // in the length bytes
    logic                 r_final, n_final;   // compression in flight is the last
    logic                 r_pad, n_pad;       // padding under way
    logic                 r_endp, n_endp;     // end seen on a block-closing byte
    logic [2:0]           r_widx, n_widx;
    logic                 r_ovalid, n_ovalid;
    logic [31:0]          r_oword, n_oword;
    logic [2:0]           r_oidx, n_oidx;
    logic                 r_olast, n_olast;

    logic                 in_fire, slot_free, put_en;
    logic [7:0]           put_val, pad_byte;
    logic [63:0]          len_sh;
    logic [AW-1:0]        rr;
    logic                 we, we_load, we_rnd;
    logic [AW-1:0]        waddr;
    logic [31:0]          wdata;
    logic [31:0]          w_m3, w_m8, w_m14, w_m16, w_new;
    sha1bs_pkg::t_round_ctl rnd_ctl;
    sha1bs_pkg::t_chain   rnd_out;

    assign o_in_ready    = (r_state == S_LOAD);
    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

    assign in_fire   = i_in_valid && o_in_ready;
    assign slot_free = !r_ovalid || i_out_ready;

    // ---- byte path: message bytes and pad bytes share one packer ----
    assign len_sh   = {29'd0, r_len, 3'd0} << {r_fill[2:0], 3'b000};
    assign pad_byte = !r_mark ? sha1bs_pkg::PAD_MARK :
                      ((r_fill == sha1bs_pkg::LEN_POS) || r_lenph) ? len_sh[63:56] :
                      8'h00;
    assign put_en   = (in_fire && i_byte_valid) || (r_state == S_PAD);
    assign put_val  = (r_state == S_PAD) ? pad_byte : i_data_byte;

    // ---- schedule RAM ports ----
    // round r reads W[r-3], W[r-8], W[r-14], W[r-16] (mod 16), issued in S_CPRE
    // or round r-1; the word written in round r is never among the next reads.
    assign rr      = (r_state == S_CPRE) ? '0 : r_round[AW-1:0] + AW'(1);
    assign we_load = put_en && (r_fill[1:0] == 2'b11);
    assign we_rnd  = (r_state == S_RND) && rnd_ctl.expand;
    assign we      = we_load || we_rnd;
    assign waddr   = we_rnd ? r_round[AW-1:0] : r_fill[FW-1:2];
    assign wdata   = we_rnd ? w_new : {r_word, put_val};

    sha1bs_wmem u_mem_a (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (rr + AW'(13)),
        .i_raddr1 (rr + AW'(8)),
        .o_rdata0 (w_m3),
        .o_rdata1 (w_m8)
    );

    sha1bs_wmem u_mem_b (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (rr + AW'(2)),
        .i_raddr1 (rr),
        .o_rdata0 (w_m14),
        .o_rdata1 (w_m16)
    );

    // ---- round unit ----
    always_comb begin
        if (r_round < RW'(20)) begin
            rnd_ctl.phase = sha1bs_pkg::PH_CH;
        end else if (r_round < RW'(40)) begin
            rnd_ctl.phase = sha1bs_pkg::PH_PAR1;
        end else if (r_round < RW'(60)) begin
            rnd_ctl.phase = sha1bs_pkg::PH_MAJ;
        end else begin
            rnd_ctl.phase = sha1bs_pkg::PH_PAR2;
        end
        rnd_ctl.expand = (r_round >= RW'(16));
    end

    sha1bs_round u_round (
        .i_ctl   (rnd_ctl),
        .i_abcde (r_abcde),
        .i_w_m3  (w_m3),
        .i_w_m8  (w_m8),
        .i_w_m14 (w_m14),
        .i_w_m16 (w_m16),
        .o_abcde (rnd_out),
        .o_w     (w_new)
    );

    // ---- sequencer ----
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_len    = r_len;
        n_word   = r_word;
        n_round  = r_round;
        n_abcde  = r_abcde;
        n_h      = r_h;
        n_mark   = r_mark;
        n_lenph  = r_lenph;
        n_final  = r_final;
        n_pad    = r_pad;
        n_endp   = r_endp;
        n_widx   = r_widx;
        n_ovalid = r_ovalid && !i_out_ready;
        n_oword  = r_oword;
        n_oidx   = r_oidx;
        n_olast  = r_olast;

        if (put_en) begin
            n_word = {r_word[15:0], put_val};
            n_fill = r_fill + FW'(1);
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (i_byte_valid) begin
                        n_len = r_len + 32'd1;
                    end
                    if (i_byte_valid && (r_fill == sha1bs_pkg::FILL_LAST)) begin
                        n_state = S_CPRE;
                        n_endp  = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                        n_pad   = 1'b1;
                    end
                end
            end
            S_PAD: begin
                if (!r_mark) begin
                    n_mark = 1'b1;
                end else if ((r_fill == sha1bs_pkg::LEN_POS) || r_lenph) begin
                    n_lenph = 1'b1;
                end
                if (r_fill == sha1bs_pkg::FILL_LAST) begin
                    n_state = S_CPRE;
                    n_final = r_lenph;
                end
            end
            S_CPRE: begin
                n_abcde = r_h;
                n_state = S_RND;
            end
            S_RND: begin
                n_abcde = rnd_out;
                if (r_round == sha1bs_pkg::ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_FIN;
                end else begin
                    n_round = r_round + RW'(1);
                end
            end
            S_FIN: begin
                for (int i = 0; i < 5; i++) begin
                    n_h[i] = r_h[i] + r_abcde[i];
                end
                if (r_final) begin
                    n_state = S_OUT;
                end else if (r_pad || r_endp) begin
                    n_state = S_PAD;
                    n_pad   = 1'b1;
                    n_endp  = 1'b0;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_h[r_widx];
                    n_oidx   = r_widx;
                    n_olast  = (r_widx == 3'd4);
                    if (r_widx == 3'd4) begin
                        n_widx  = '0;
                        n_h     = sha1bs_pkg::H_INIT;
                        n_len   = '0;
                        n_mark  = 1'b0;
                        n_lenph = 1'b0;
                        n_final = 1'b0;
                        n_pad   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_h      <= sha1bs_pkg::H_INIT;
            r_mark   <= 1'b0;
            r_lenph  <= 1'b0;
            r_final  <= 1'b0;
            r_pad    <= 1'b0;
            r_endp   <= 1'b0;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_round  <= n_round;
            r_h      <= n_h;
            r_mark   <= n_mark;
            r_lenph  <= n_lenph;
            r_final  <= n_final;
            r_pad    <= n_pad;
            r_endp   <= n_endp;
            r_widx   <= n_widx;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_abcde <= n_abcde;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

endmodule

/* src/sha1bs_checker.sv */
// Port-level checks for the SHA-1 byte stream hasher, bound to the top level.
// Depends on sha1_byte_stream_hasher_top port names only.
module sha1bs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // held output transfer keeps its digest word and index
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("output payload changed while stalled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd4)))
        else $error("last flag does not match word index");

    // words of one digest follow in order with no gaps
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    // no new input while a digest is still being handed out
    a_no_input_mid_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_word |-> !o_in_ready)
        else $error("input taken in the middle of a digest");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind sha1_byte_stream_hasher_top sha1bs_checker u_sha1bs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

/* tb/sha1_digest_checker.sv */
`timescale 1ns / 1ps
// Digest checker for the SHA-1 byte stream hasher: watches both channels,
// predicts the digest words and compares. Uses sha1bs_pkg for the round phase.
module sha1_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [4:0][31:0] HASH_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                            32'hefcdab89, 32'h67452301};
    localparam logic [3:0][31:0] MIX_K   = {32'hca62c1d6, 32'h8f1bbcdc,
                                            32'h6ed9eba1, 32'h5a827999};
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LENGTH_OFFSET = 6'd56;
    localparam int         REPORT_MAX    = 10;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_entry;

    logic [31:0]   chain_h [5];
    logic [31:0]   sched_w [16];
    logic [5:0]    fill_cnt;
    logic [31:0]   byte_count;
    t_digest_entry digest_queue [$];
    int            mismatches;

    function automatic void restart_hash();
        for (int i = 0; i < 5; i++) chain_h[i] = HASH_IV[i];
        fill_cnt   = '0;
        byte_count = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, e, f, w;
        sha1bs_pkg::t_phase ph;
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16]
                  ^ sched_w[(r + 2) % 16] ^ sched_w[r % 16];
                sched_w[r % 16] = {w[30:0], w[31]};
            end
            ph = sha1bs_pkg::t_phase'(r / 20);
            case (ph)
                sha1bs_pkg::PH_CH:   f = (d ^ (b & (c ^ d))) + MIX_K[0];
                sha1bs_pkg::PH_PAR1: f = (b ^ c ^ d) + MIX_K[1];
                sha1bs_pkg::PH_MAJ:  f = ((b & c) | (d & (b | c))) + MIX_K[2];
                default:             f = (b ^ c ^ d) + MIX_K[3];
            endcase
            f = f + {a[26:0], a[31:27]} + e + sched_w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = f;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endfunction

    // big-endian packing into the 16-word block
    function automatic void put_byte(logic [7:0] value);
        sched_w[fill_cnt[5:2]][8 * (3 - fill_cnt[1:0]) +: 8] = value;
        fill_cnt = fill_cnt + 6'd1;
        if (fill_cnt == 6'd0) compress_block();
    endfunction

    function automatic void absorb_item(logic [7:0] value, logic has_byte, logic closes);
        logic [63:0]   bit_len;
        t_digest_entry ent;
        if (has_byte) begin
            byte_count = byte_count + 32'd1;
            put_byte(value);
        end
        if (closes) begin
            bit_len = {29'd0, byte_count, 3'd0};
            put_byte(PAD_BYTE);
            while (fill_cnt != LENGTH_OFFSET) put_byte(8'h00);
            for (int k = 7; k >= 0; k--) put_byte(bit_len[8 * k +: 8]);
            for (int i = 0; i < 5; i++) begin
                ent.word = chain_h[i];
                ent.idx  = 3'(i);
                ent.last = (i == 4);
                digest_queue.push_back(ent);
            end
            restart_hash();
        end
    endfunction

    function automatic void check_word();
        t_digest_entry ent;
        if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected digest word %08h index %0d last %0b",
                         i_digest_word, i_word_index, i_last_word);
        end else begin
            ent = digest_queue.pop_front();
            if (i_digest_word !== ent.word || i_word_index !== ent.idx
                    || i_last_word !== ent.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("digest mismatch: exp %08h/%0d/%0b got %08h/%0d/%0b",
                             ent.word, ent.idx, ent.last,
                             i_digest_word, i_word_index, i_last_word);
            end
        end
    endfunction

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        for (int i = 0; i < 16; i++) sched_w[i] = '0;
        restart_hash();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_hash();
            digest_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                absorb_item(i_data_byte, i_byte_valid, i_end_of_message);
            if (i_out_valid && i_out_ready)
                check_word();
        end
        o_fail_count = mismatches;
        o_pending    = digest_queue.size();
    end

endmodule

/* tb/sha1_byte_stream_hasher_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the SHA-1 byte stream hasher: clock, reset, message
// stimulus, receiver stalls and verdict. Uses sha1_digest_checker and the RTL.
module sha1_byte_stream_hasher_top_tb;

    localparam int ITEM_TARGET = 430;   // message items to send (noise not counted)
    localparam int QUIET_MARK  = 370;   // from here on, no idling on either side
    localparam int STALL_LIMIT = 4000;  // cycles without any transfer
    localparam int TAIL_CYCLES = 300;   // settle time once all digests are in

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_end_of_message;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int fail_count;
    int pending_words;
    int items_sent;
    int quiet_cycles;
    bit quiet_tail;

    sha1_byte_stream_hasher_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    // Checker sits beside the DUT on the same wires; it owns prediction.
    sha1_digest_checker u_digest_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_digest_word    (o_digest_word),
        .i_word_index     (o_word_index),
        .i_last_word      (o_last_word),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any transfer on either channel, or reset, restarts the count.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sha1_byte_stream_hasher_top verification failed");
            $finish;
        end
    end

    // Receiver: random bursts of ready and stall, with the odd long run
    // of ready so back-to-back digest words get through too. Always ready at
    // the tail of the run.
    initial begin : receiver
        int unsigned run_len;
        int unsigned pick;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            pick = $urandom_range(0, 9);
            if (quiet_tail || pick >= 7) begin
                i_out_ready <= 1'b1;
                run_len = quiet_tail ? 1 : $urandom_range(20, 120);
            end else if (pick >= 3) begin
                i_out_ready <= 1'b0;
                run_len = $urandom_range(1, 19);
            end else begin
                i_out_ready <= 1'b1;
                run_len = $urandom_range(1, 19);
            end
            repeat (run_len) @(negedge i_clk);
        end
    end

    // One item on the input channel. Entered at a falling edge; returns at
    // the falling edge after the transfer. Ready is read right at the rising
    // edge, before any register in the DUT has updated.
    task automatic send_item(input logic [7:0] value, input logic has_byte,
                             input logic closes);
        i_in_valid       <= 1'b1;
        i_data_byte      <= value;
        i_byte_valid     <= has_byte;
        i_end_of_message <= closes;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (has_byte || closes) items_sent++;
    endtask

    // Sender gap; payload is scrambled while valid is low.
    task automatic hold_off(input int unsigned cycles);
        i_in_valid       <= 1'b0;
        i_data_byte      <= 8'($urandom);
        i_byte_valid     <= 1'($urandom);
        i_end_of_message <= 1'($urandom);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic maybe_idle(input bit steady);
        if (!quiet_tail && !steady && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 19));
    endtask

    // Pause until every predicted digest word has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_words != 0);
    endtask

    // One well-formed message with random content. The final byte either
    // rides on the closing transfer or a separate empty closing item follows.
    // Now and then a noise item (no byte, no end) is slipped in.
    task automatic send_message(input int unsigned len);
        bit          ride_last;
        bit          steady;
        logic [7:0]  value;
        ride_last = 1'($urandom);
        steady    = ($urandom_range(0, 2) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            value = 8'($urandom_range(0, 255));
            send_item(value, 1'b1, ride_last && (i == len - 1));
            maybe_idle(steady);
        end
        if (!ride_last || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        maybe_idle(steady);
        if (items_sent >= QUIET_MARK) quiet_tail = 1'b1;
    endtask

    initial begin : stimulus
        int unsigned around_pad [8];
        int unsigned sel;
        int unsigned len;
        around_pad = '{55, 56, 57, 63, 64, 65, 119, 120};
        items_sent       = 0;
        quiet_tail       = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_data_byte      = 8'h00;
        i_byte_valid     = 1'b0;
        i_end_of_message = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, single-byte messages at both byte
        // extremes, "abc" with noise in between and an empty closing item,
        // then a message whose last byte rides on the end transfer.
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        hold_off(3);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b1);
        drain();

        // Random messages: mostly short, some around the padding boundaries
        // (length field fits or spills into an extra block), a few long ones.
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(0, 12);
            else if (sel < 9)
                len = around_pad[$urandom_range(0, 7)];
            else
                len = $urandom_range(13, 140);
            send_message(len);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("sha1_byte_stream_hasher_top verification clean");
        else
            $display("sha1_byte_stream_hasher_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/sha1bs_pkg.sv
src/sha1bs_wmem.sv
src/sha1bs_round.sv
src/sha1_byte_stream_hasher_top.sv
src/sha1bs_checker.sv
tb/sha1_digest_checker.sv
tb/sha1_byte_stream_hasher_top_tb.sv
